// ===== rtl/aac_sfs_pkg.sv =====
// aac_sfs_pkg: shared types, codes and helper functions for the audio
// superframe splitter; no dependencies
package aac_sfs_pkg;

    localparam int BORDER_BITS = 12;

    // configuration register indexes
    localparam logic REG_RATE_CODE        = 1'b0;
    localparam logic REG_SUPERFRAME_BYTES = 1'b1;

    // rate code that selects the short superframe
    localparam logic [2:0] RATE_CODE_FIVE = 3'd3;
    localparam logic [3:0] NF_SHORT       = 4'd5;
    localparam logic [3:0] NF_LONG        = 4'd10;

    // bound on the frame index of any result
    localparam logic [3:0] FRAME_IDX_LIMIT = 4'd10;

    // result source select
    localparam logic [2:0] EMIT_NONE      = 3'd0;
    localparam logic [2:0] EMIT_PAY_CRC   = 3'd1;
    localparam logic [2:0] EMIT_BYTE_LIVE = 3'd2;
    localparam logic [2:0] EMIT_BYTE_HELD = 3'd3;
    localparam logic [2:0] EMIT_FLUSH_CRC = 3'd4;
    localparam logic [2:0] EMIT_ERROR     = 3'd5;

    typedef struct packed {
        logic       accept;
        logic [2:0] emit;
        logic       cf_adv;
        logic       chk_step;
        logic       drop_set;
    } cmd_t;

    typedef struct packed {
        logic slot_free;
        logic hdr_last;
        logic crc_last;
        logic pay_emit;
        logic pay_first;
        logic pay_last;
        logic held_last;
        logic chk_last;
        logic hdr_bad;
        logic flush_hit;
    } sts_t;

    // header length in bytes for a frame count
    function automatic logic [3:0] hdr_bytes(input logic [3:0] nf);
        logic [7:0] bits;
        begin
            bits = (8'(nf) - 8'd1) * 8'(BORDER_BITS) + 8'd7;
            return bits[6:3];
        end
    endfunction

    // border completed by header byte k, zero when none; odd slots leave a nibble
    function automatic logic [3:0] border_slot(input logic [3:0] k);
        logic [3:0] s;
        begin
            case (k)
                4'd1:    s = 4'd1;
                4'd2:    s = 4'd2;
                4'd4:    s = 4'd3;
                4'd5:    s = 4'd4;
                4'd7:    s = 4'd5;
                4'd8:    s = 4'd6;
                4'd10:   s = 4'd7;
                4'd11:   s = 4'd8;
                4'd13:   s = 4'd9;
                default: s = 4'd0;
            endcase
            return s;
        end
    endfunction

endpackage

// ===== rtl/aac_superframe_splitter_core.sv =====
// aac_superframe_splitter_core: top level of the audio superframe splitter;
// holds the configuration registers, instantiates aac_sfs_ctrl and aac_sfs_datapath
//
// Usage: superframe bytes enter on the input channel (in_valid/in_stall),
// superframe_start marking byte 0. Each frame leaves on the output channel
// (out_valid/out_stall) as its crc request followed by its payload requests,
// frame_end on the last; a bad header gives one header_error request and the
// rest of the superframe is dropped. rate_code and superframe_bytes are
// written through cfg_write_en/cfg_index/cfg_data; the user must write them
// only while the block is idle, as the block itself does not enforce this.
// The single output register sets the pace: while the receiver stalls, the
// held request stays and the next input byte is stalled behind it. Header,
// crc and payload bytes are otherwise taken one per cycle in the run state;
// a frame's first payload byte is held while its crc request goes out. The
// last header byte is followed by a check of each border and a verdict, the
// end of the crc bytes or of a frame by a flush of the empty frames.
// Reset clears the position counters and drops input until a start mark.
module aac_superframe_splitter_core
    import aac_sfs_pkg::*;
#(
    parameter int MAX_FRAMES = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [0:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  audio_byte,
    input  logic        superframe_start,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic [3:0]  frame_index,
    output logic        is_crc,
    output logic        frame_end,
    output logic        header_error
);

    logic [2:0]  rate_code_reg, rate_code_next;
    logic [11:0] superframe_bytes_reg, superframe_bytes_next;
    cmd_t        cmd;
    sts_t        sts;

    always_comb
    begin
        rate_code_next        = rate_code_reg;
        superframe_bytes_next = superframe_bytes_reg;
        if (cfg_write_en)
        begin
            case (cfg_index[0])
                REG_RATE_CODE:        rate_code_next = cfg_data[2:0];
                REG_SUPERFRAME_BYTES: superframe_bytes_next = cfg_data;
                default:              rate_code_next = rate_code_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_code_reg        <= 3'd0;
            superframe_bytes_reg <= 12'd0;
        end
        else
        begin
            rate_code_reg        <= rate_code_next;
            superframe_bytes_reg <= superframe_bytes_next;
        end
    end

    aac_sfs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    aac_sfs_datapath #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .rate_code        (rate_code_reg),
        .superframe_bytes (superframe_bytes_reg),
        .audio_byte       (audio_byte),
        .superframe_start (superframe_start),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .out_byte         (out_byte),
        .frame_index      (frame_index),
        .is_crc           (is_crc),
        .frame_end        (frame_end),
        .header_error     (header_error)
    );

endmodule

// ===== rtl/aac_sfs_datapath.sv =====
// aac_sfs_datapath: byte position, border and crc stores, header check
// registers and the output register; uses aac_sfs_pkg
module aac_sfs_datapath
    import aac_sfs_pkg::*;
#(
    parameter int MAX_FRAMES = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic [2:0]  rate_code,
    input  logic [11:0] superframe_bytes,
    input  logic [7:0]  audio_byte,
    input  logic        superframe_start,
    input  logic        out_stall,
    output logic        out_valid,
    output logic [7:0]  out_byte,
    output logic [3:0]  frame_index,
    output logic        is_crc,
    output logic        frame_end,
    output logic        header_error
);

    localparam int IW = $clog2(MAX_FRAMES);
    localparam logic [3:0] MAX_NF = 4'(MAX_FRAMES);

    logic [BORDER_BITS-1:0] border_mem [MAX_FRAMES];
    logic [7:0]             crc_mem [MAX_FRAMES];

    logic [11:0] pos_reg, pos_next;
    logic [15:0] acc_reg, acc_next;
    logic [3:0]  cf_reg, cf_next;
    logic        drop_reg, drop_next;
    logic [3:0]  chk_idx_reg, chk_idx_next;
    logic        bad_reg, bad_next;
    logic        out_valid_reg, out_valid_next;

    logic [11:0] prev_reg, start_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [7:0]  out_byte_reg;
    logic [3:0]  frame_index_reg;
    logic        is_crc_reg, frame_end_reg, header_error_reg;

    logic [3:0]  nf_raw, nf, hdr;
    logic [4:0]  body_start;
    logic [11:0] eff_pos, pos_inc, crc_off;
    logic [15:0] eff_acc, acc_hdr;
    logic [3:0]  eff_cf, cf_plus, rd_addr, slot;
    logic        eff_drop;
    logic        in_hdr, in_crc, in_pay, beyond;
    logic [BORDER_BITS-1:0] border_wr, border_rd;
    logic        border_we, crc_we;
    logic [7:0]  crc_rd;

    logic signed [13:0] len_s, total_s, pos_s, p_s, fend_s, start_s, rd_s, prev_s, fl_s;
    logic        chk_bad_now;

    logic        load;
    logic [7:0]  sel_byte;
    logic [3:0]  sel_idx;
    logic        sel_crc, sel_end, sel_err;

    // frame layout from the current registers
    always_comb
    begin
        nf_raw     = (rate_code == RATE_CODE_FIVE) ? NF_SHORT : NF_LONG;
        nf         = (nf_raw > MAX_NF) ? MAX_NF : nf_raw;
        hdr        = hdr_bytes(nf);
        body_start = {1'b0, hdr} + {1'b0, nf};
    end

    // a start mark restarts the superframe at byte 0
    assign eff_pos  = superframe_start ? 12'd0 : pos_reg;
    assign eff_acc  = superframe_start ? 16'd0 : acc_reg;
    assign eff_cf   = superframe_start ? 4'd0 : cf_reg;
    assign eff_drop = superframe_start ? 1'b0 : drop_reg;
    assign pos_inc  = eff_pos + 12'd1;
    assign crc_off  = eff_pos - {8'd0, hdr};

    assign in_hdr = !eff_drop && (eff_pos < {8'd0, hdr});
    assign beyond = !eff_drop && !in_hdr && (eff_pos >= superframe_bytes);
    assign in_crc = !eff_drop && !in_hdr && !beyond && (eff_pos < {7'd0, body_start});
    assign in_pay = !eff_drop && !in_hdr && !beyond && !in_crc;

    // border unpacking: 12-bit fields packed msb first over byte pairs
    always_comb
    begin
        slot      = border_slot(eff_pos[3:0]);
        border_wr = '0;
        if (slot == 4'd0)
        begin
            acc_hdr = {eff_acc[7:0], audio_byte};
        end
        else if (slot[0])
        begin
            border_wr = {eff_acc[7:0], audio_byte[7:4]};
            acc_hdr   = {12'd0, audio_byte[3:0]};
        end
        else
        begin
            border_wr = {eff_acc[3:0], audio_byte};
            acc_hdr   = 16'd0;
        end
    end

    assign border_we = cmd.accept && in_hdr && (slot != 4'd0) && (slot < nf);
    assign crc_we    = cmd.accept && in_crc;

    // single read port on the border store: check index while checking
    assign cf_plus   = cf_reg + 4'd1;
    assign rd_addr   = (chk_idx_reg != 4'd0) ? chk_idx_reg : cf_plus;
    assign border_rd = (rd_addr < MAX_NF) ? border_mem[rd_addr[IW-1:0]] : '0;
    assign crc_rd    = (cf_reg < MAX_NF) ? crc_mem[cf_reg[IW-1:0]] : 8'd0;

    always_comb
    begin
        len_s   = $signed({2'b00, superframe_bytes});
        total_s = len_s - $signed({9'd0, body_start});
        pos_s   = $signed({2'b00, pos_reg});
        p_s     = pos_s - $signed({9'd0, body_start});
        rd_s    = $signed({2'b00, border_rd});
        start_s = $signed({2'b00, start_reg});
        prev_s  = $signed({2'b00, prev_reg});
        fend_s  = (cf_plus < nf) ? rd_s : total_s;
        fl_s    = rd_s - prev_s;
        chk_bad_now = (fl_s < 14'sd0) || (fl_s >= len_s);
    end

    always_comb
    begin
        sts.slot_free = !out_valid_reg || !out_stall;
        sts.hdr_last  = in_hdr && (pos_inc == {8'd0, hdr});
        sts.crc_last  = in_crc && (pos_inc == {7'd0, body_start});
        sts.pay_emit  = in_pay && (cf_reg < nf);
        sts.pay_first = (p_s == start_s);
        sts.pay_last  = ((p_s + 14'sd1) >= fend_s);
        sts.held_last = last_reg;
        sts.chk_last  = (chk_idx_reg == (nf - 4'd1));
        sts.hdr_bad   = bad_reg || ((total_s - prev_s) < 14'sd0);
        sts.flush_hit = (cf_reg < nf) && (fend_s <= start_s);
    end

    always_comb
    begin
        pos_next     = pos_reg;
        acc_next     = acc_reg;
        cf_next      = cf_reg;
        drop_next    = drop_reg;
        chk_idx_next = chk_idx_reg;
        bad_next     = bad_reg;
        if (cmd.accept)
        begin
            pos_next  = (in_hdr || in_crc || in_pay) ? pos_inc : eff_pos;
            acc_next  = in_hdr ? acc_hdr : eff_acc;
            cf_next   = eff_cf;
            drop_next = eff_drop || beyond;
            if (sts.hdr_last)
            begin
                chk_idx_next = 4'd1;
                bad_next     = 1'b0;
            end
        end
        if (cmd.cf_adv)
        begin
            cf_next = cf_plus;
        end
        if (cmd.chk_step)
        begin
            bad_next     = bad_reg || chk_bad_now;
            chk_idx_next = sts.chk_last ? 4'd0 : chk_idx_reg + 4'd1;
        end
        if (cmd.drop_set)
        begin
            drop_next = 1'b1;
        end
    end

    // result source mux
    always_comb
    begin
        sel_byte = 8'd0;
        sel_idx  = cf_reg;
        sel_crc  = 1'b0;
        sel_end  = 1'b0;
        sel_err  = 1'b0;
        case (cmd.emit)
            EMIT_PAY_CRC:
            begin
                sel_byte = crc_rd;
                sel_crc  = 1'b1;
            end
            EMIT_BYTE_LIVE:
            begin
                sel_byte = audio_byte;
                sel_end  = sts.pay_last;
            end
            EMIT_BYTE_HELD:
            begin
                sel_byte = byte_reg;
                sel_end  = last_reg;
            end
            EMIT_FLUSH_CRC:
            begin
                sel_byte = crc_rd;
                sel_crc  = 1'b1;
                sel_end  = 1'b1;
            end
            EMIT_ERROR:
            begin
                sel_idx = 4'd0;
                sel_err = 1'b1;
            end
            default:
            begin
                sel_idx = cf_reg;
            end
        endcase
    end

    assign load           = (cmd.emit != EMIT_NONE);
    assign out_valid_next = load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 12'd0;
            acc_reg       <= 16'd0;
            cf_reg        <= 4'd0;
            drop_reg      <= 1'b1;
            chk_idx_reg   <= 4'd0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            acc_reg       <= acc_next;
            cf_reg        <= cf_next;
            drop_reg      <= drop_next;
            chk_idx_reg   <= chk_idx_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (border_we)
        begin
            border_mem[slot[IW-1:0]] <= border_wr;
        end
        if (crc_we)
        begin
            crc_mem[crc_off[IW-1:0]] <= audio_byte;
        end
        if (cmd.accept)
        begin
            byte_reg <= audio_byte;
            last_reg <= sts.pay_last;
            if (superframe_start)
            begin
                start_reg <= 12'd0;
            end
            if (sts.hdr_last)
            begin
                prev_reg <= 12'd0;
            end
        end
        // next frame starts where this one ends
        if (cmd.cf_adv)
        begin
            start_reg <= border_rd;
        end
        if (cmd.chk_step)
        begin
            prev_reg <= border_rd;
        end
        if (load)
        begin
            out_byte_reg     <= sel_byte;
            frame_index_reg  <= sel_idx;
            is_crc_reg       <= sel_crc;
            frame_end_reg    <= sel_end;
            header_error_reg <= sel_err;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign frame_index  = frame_index_reg;
    assign is_crc       = is_crc_reg;
    assign frame_end    = frame_end_reg;
    assign header_error = header_error_reg;

endmodule

// ===== rtl/aac_sfs_ctrl.sv =====
// aac_sfs_ctrl: sequencer for the superframe splitter; issues datapath
// commands from its status; uses aac_sfs_pkg
module aac_sfs_ctrl
    import aac_sfs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] S_RUN     = 3'd0;
    localparam logic [2:0] S_BYTE    = 3'd1;
    localparam logic [2:0] S_FLUSH   = 3'd2;
    localparam logic [2:0] S_CHECK   = 3'd3;
    localparam logic [2:0] S_VERDICT = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        cmd.emit   = EMIT_NONE;
        state_next = state_reg;
        in_stall   = 1'b1;
        case (state_reg)
            S_RUN:
            begin
                in_stall = !sts.slot_free;
                if (in_valid && sts.slot_free)
                begin
                    cmd.accept = 1'b1;
                    if (sts.hdr_last)
                    begin
                        state_next = S_CHECK;
                    end
                    else if (sts.crc_last)
                    begin
                        state_next = S_FLUSH;
                    end
                    else if (sts.pay_emit)
                    begin
                        // first payload byte of a frame follows its crc request
                        if (sts.pay_first)
                        begin
                            cmd.emit   = EMIT_PAY_CRC;
                            state_next = S_BYTE;
                        end
                        else
                        begin
                            cmd.emit = EMIT_BYTE_LIVE;
                            if (sts.pay_last)
                            begin
                                cmd.cf_adv = 1'b1;
                                state_next = S_FLUSH;
                            end
                        end
                    end
                end
            end
            S_BYTE:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit = EMIT_BYTE_HELD;
                    if (sts.held_last)
                    begin
                        cmd.cf_adv = 1'b1;
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        state_next = S_RUN;
                    end
                end
            end
            S_FLUSH:
            begin
                // zero-length frames go out as lone crc requests
                if (sts.flush_hit)
                begin
                    if (sts.slot_free)
                    begin
                        cmd.emit   = EMIT_FLUSH_CRC;
                        cmd.cf_adv = 1'b1;
                    end
                end
                else
                begin
                    state_next = S_RUN;
                end
            end
            S_CHECK:
            begin
                cmd.chk_step = 1'b1;
                if (sts.chk_last)
                begin
                    state_next = S_VERDICT;
                end
            end
            S_VERDICT:
            begin
                if (sts.hdr_bad)
                begin
                    if (sts.slot_free)
                    begin
                        cmd.emit     = EMIT_ERROR;
                        cmd.drop_set = 1'b1;
                        state_next   = S_RUN;
                    end
                end
                else
                begin
                    state_next = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/aac_sfs_checker.sv =====
// aac_sfs_checker: port-level checks on the splitter's output channel,
// bound to aac_superframe_splitter_core; uses aac_sfs_pkg
module aac_sfs_checker
    import aac_sfs_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic [3:0] frame_index,
    input logic       is_crc,
    input logic       frame_end,
    input logic       header_error
);

    // an error request carries nothing else
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && header_error |->
            out_byte == 8'd0 && frame_index == 4'd0 && !is_crc && !frame_end)
        else $error("error request with nonzero fields");

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frame_index < FRAME_IDX_LIMIT)
        else $error("frame index out of range");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            out_valid && $stable(out_byte) && $stable(frame_index) && $stable(is_crc)
            && $stable(frame_end) && $stable(header_error))
        else $error("stalled output request changed");

endmodule

bind aac_superframe_splitter_core aac_sfs_checker u_checker (.*);
